### rtl/strided_element_offset_top_defines.svh
`ifndef STRIDED_ELEMENT_OFFSET_TOP_DEFINES_SVH
`define STRIDED_ELEMENT_OFFSET_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SEO_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("seo check failed");

// next-cycle implication, clocked on clk, off during reset
`define SEO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("seo check failed");

`endif

### rtl/seo_pkg.sv
package seo_pkg;

  localparam int MAX_DIMS        = 4;
  localparam int SHAPE_W         = 16;
  localparam int INDEX_W         = 32;
  localparam int OFFSET_W        = 41;
  localparam int BITS_PER_STAGE  = 4;
  localparam int DIV_STAGES      = INDEX_W / BITS_PER_STAGE;
  localparam int STAGES_PER_STEP = DIV_STAGES + 1;
  localparam int LAST_STAGE      = MAX_DIMS * STAGES_PER_STEP;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DIM_COUNT    = 2'd0,
    REG_SHAPE_WORDS  = 2'd1,
    REG_STRIDE_WORDS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                        valid;
    logic [INDEX_W-1:0]          quo;
    logic [SHAPE_W-1:0]          rem;
    logic signed [OFFSET_W-1:0]  acc;
  } pipe_t;

  // zero means one, above max saturates
  function automatic logic [2:0] dims_in_use(input logic [2:0] dc);
    logic [2:0] n;
    n = dc;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(MAX_DIMS)) n = 3'(MAX_DIMS);
    return n;
  endfunction

  // step j works on dimension n-1-j; steps past n divide by one
  function automatic logic [SHAPE_W-1:0] step_shape(input logic [63:0] shapes,
                                                    input logic [2:0] dc, input int j);
    logic [2:0]         n;
    logic [2:0]         d3;
    logic [SHAPE_W-1:0] s;
    n  = dims_in_use(dc);
    d3 = n - 3'(j) - 3'd1;
    s  = shapes[16*d3[1:0] +: 16];
    if (3'(j) >= n || s == '0) s = SHAPE_W'(1);
    return s;
  endfunction

  function automatic logic signed [SHAPE_W-1:0] step_stride(input logic [63:0] strides,
                                                            input logic [2:0] dc, input int j);
    logic [2:0] n;
    logic [2:0] d3;
    n  = dims_in_use(dc);
    d3 = n - 3'(j) - 3'd1;
    if (3'(j) >= n) return '0;
    return signed'(strides[16*d3[1:0] +: 16]);
  endfunction

endpackage

### rtl/seo_div_stage.sv
module seo_div_stage import seo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [SHAPE_W-1:0] divisor,
  input  pipe_t              din,
  output pipe_t              dout
);

  pipe_t dout_next;

  // restoring division, a few quotient bits per stage
  always_comb begin
    logic [SHAPE_W:0]   trial;
    logic [SHAPE_W-1:0] r;
    logic [INDEX_W-1:0] q;
    r = din.rem;
    q = din.quo;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      trial = {r, q[INDEX_W-1]};
      q = {q[INDEX_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        r = SHAPE_W'(trial - {1'b0, divisor});
        q[0] = 1'b1;
      end else begin
        r = trial[SHAPE_W-1:0];
      end
    end
    dout_next     = din;
    dout_next.quo = q;
    dout_next.rem = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

### rtl/strided_element_offset_top.sv
// strided element offset generator: turns a flat row-major element index into
// the signed element offset of that element in a strided view of up to four
// dimensions (the last dimension in use is the innermost). the index is split
// into coordinates by successive division by each shape, innermost first, and
// the offset is the sum of coordinate times signed stride. a shape of zero
// counts as one. an index at or past the product of the shapes wraps and sets
// out_of_range. one request is taken every cycle unless the output stalls,
// which freezes the whole pipe. four chained 32 by 16 bit dividers resolve
// four quotient bits per stage, each followed by a multiply-accumulate stage.
// configuration must be written only while the pipe is empty; no check here.
module strided_element_offset_top import seo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // index requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] element_index
  // offset results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [40:0] element_offset, rest zero
  output logic        m_axis_tuser    // [0] out_of_range
);

`include "strided_element_offset_top_defines.svh"

  logic [2:0]  dim_count;
  logic [63:0] shape_words;
  logic [63:0] stride_words;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count    <= 3'd1;
      shape_words  <= 64'd1;
      stride_words <= 64'd1;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_DIM_COUNT:    dim_count    <= cfg_data[2:0];
        REG_SHAPE_WORDS:  shape_words  <= cfg_data;
        REG_STRIDE_WORDS: stride_words <= cfg_data;
        default: ;
      endcase
    end
  end

  // step divisor, stride: user keeps static while pipe holds requests; unchecked
  logic        [SHAPE_W-1:0] div_shape  [MAX_DIMS];
  logic signed [SHAPE_W-1:0] div_stride [MAX_DIMS];

  always_comb begin
    for (int j = 0; j < MAX_DIMS; j++) begin
      div_shape[j]  = step_shape(shape_words, dim_count, j);
      div_stride[j] = step_stride(stride_words, dim_count, j);
    end
  end

  // whole-pipe advance: moves unless a finished result waits untaken
  logic  en;
  logic  in_acc;
  pipe_t pipe [LAST_STAGE+1];
  pipe_t pipe0_next;

  assign en            = !pipe[LAST_STAGE].valid || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pipe0_next.valid = s_axis_tvalid;
    pipe0_next.quo   = s_axis_tdata;
    pipe0_next.rem   = '0;
    pipe0_next.acc   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0] <= pipe0_next;
    end
  end

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_step
    pipe_t mac_next;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      seo_div_stage u_div (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .divisor (div_shape[j]),
        .din     (pipe[j*STAGES_PER_STEP + k]),
        .dout    (pipe[j*STAGES_PER_STEP + k + 1])
      );
    end

    // remainder is this dimension's coordinate
    always_comb begin
      logic signed [SHAPE_W*2:0] prod;
      prod     = signed'({1'b0, pipe[j*STAGES_PER_STEP + DIV_STAGES].rem}) * div_stride[j];
      mac_next = pipe[j*STAGES_PER_STEP + DIV_STAGES];
      mac_next.acc = mac_next.acc + OFFSET_W'(prod);
      mac_next.rem = '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[(j+1)*STAGES_PER_STEP].valid <= 1'b0;
      end else if (en) begin
        pipe[(j+1)*STAGES_PER_STEP] <= mac_next;
      end
    end

    // a coordinate never reaches its shape
    `SEO_ASSERT(a_coord_below_shape, pipe[j*STAGES_PER_STEP + DIV_STAGES].valid, pipe[j*STAGES_PER_STEP + DIV_STAGES].rem < div_shape[j])
  end

  // quotient left after the last division is index / element count
  assign m_axis_tvalid = pipe[LAST_STAGE].valid;
  assign m_axis_tdata  = {7'd0, pipe[LAST_STAGE].acc};
  assign m_axis_tuser  = (pipe[LAST_STAGE].quo != '0);

  `SEO_ASSERT_NEXT(a_accept_enters, in_acc, pipe[0].valid)
  `SEO_ASSERT_NEXT(a_stall_holds_mid, !en, $stable(pipe[MAX_DIMS/2*STAGES_PER_STEP]))
  `SEO_ASSERT(a_first_step_clears, pipe[STAGES_PER_STEP].valid, pipe[STAGES_PER_STEP].rem == '0)

endmodule
